@@ hw/rtl/svt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package svt_pkg;

  localparam int TABLE_POINTS_DEF = 33;
  localparam int TABLE_CAP = 64;
  localparam int LUT_IDX_W = 6;
  localparam int MV_W = 16;
  localparam int TEMP_W = 8;
  localparam int QUO_W = 8;
  localparam int NUM_W = MV_W + QUO_W;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS_PER_STAGE;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [MV_W-1:0] mv;
  } lut_point_t;

  typedef struct packed {
    logic ok;
    logic signed [TEMP_W-1:0] base;
    logic neg;
    logic [QUO_W-1:0] mag;
    logic [MV_W-1:0] d;
    logic [MV_W-1:0] span;
  } seg_t;

  typedef struct packed {
    logic ok;
    logic signed [TEMP_W-1:0] base;
    logic neg;
    logic [NUM_W-1:0] rem;
    logic [MV_W-1:0] span;
    logic [QUO_W-1:0] quo;
  } div_work_t;

  function automatic lut_point_t lut_at(input logic [LUT_IDX_W-1:0] idx);
    lut_point_t p;
    p = '0;
    case (idx)
      6'd0: p = '{temp: -8'sd40, mv: 16'd2440};
      6'd1: p = '{temp: -8'sd35, mv: 16'd2420};
      6'd2: p = '{temp: -8'sd30, mv: 16'd2400};
      6'd3: p = '{temp: -8'sd25, mv: 16'd2380};
      6'd4: p = '{temp: -8'sd20, mv: 16'd2350};
      6'd5: p = '{temp: -8'sd15, mv: 16'd2320};
      6'd6: p = '{temp: -8'sd10, mv: 16'd2270};
      6'd7: p = '{temp: -8'sd5, mv: 16'd2230};
      6'd8: p = '{temp: 8'sd0, mv: 16'd2170};
      6'd9: p = '{temp: 8'sd5, mv: 16'd2110};
      6'd10: p = '{temp: 8'sd10, mv: 16'd2050};
      6'd11: p = '{temp: 8'sd15, mv: 16'd1990};
      6'd12: p = '{temp: 8'sd20, mv: 16'd1920};
      6'd13: p = '{temp: 8'sd25, mv: 16'd1860};
      6'd14: p = '{temp: 8'sd30, mv: 16'd1800};
      6'd15: p = '{temp: 8'sd35, mv: 16'd1740};
      6'd16: p = '{temp: 8'sd40, mv: 16'd1680};
      6'd17: p = '{temp: 8'sd45, mv: 16'd1630};
      6'd18: p = '{temp: 8'sd50, mv: 16'd1590};
      6'd19: p = '{temp: 8'sd55, mv: 16'd1550};
      6'd20: p = '{temp: 8'sd60, mv: 16'd1510};
      6'd21: p = '{temp: 8'sd65, mv: 16'd1480};
      6'd22: p = '{temp: 8'sd70, mv: 16'd1450};
      6'd23: p = '{temp: 8'sd75, mv: 16'd1430};
      6'd24: p = '{temp: 8'sd80, mv: 16'd1400};
      6'd25: p = '{temp: 8'sd85, mv: 16'd1380};
      6'd26: p = '{temp: 8'sd90, mv: 16'd1370};
      6'd27: p = '{temp: 8'sd95, mv: 16'd1350};
      6'd28: p = '{temp: 8'sd100, mv: 16'd1340};
      6'd29: p = '{temp: 8'sd105, mv: 16'd1330};
      6'd30: p = '{temp: 8'sd110, mv: 16'd1320};
      6'd31: p = '{temp: 8'sd115, mv: 16'd1310};
      6'd32: p = '{temp: 8'sd120, mv: 16'd1300};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sensor_voltage_to_temperature_top.sv @@
// Throughput: one item per cycle while the output is not held; the stages are
// a table compare, a segment fetch, a multiply, four two-bit divide steps and
// the output register. The whole pipeline stalls together while the output is held.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module sensor_voltage_to_temperature_top #(
  parameter int TABLE_POINTS = svt_pkg::TABLE_POINTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] voltage_mv
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [7:0] m_axis_tdata,        // [7:0] temp_c
  output logic m_axis_tuser               // [0] valid_res
);
  import svt_pkg::*;

  logic advance;
  logic seg_valid;
  seg_t seg;
  logic mul_valid;
  div_work_t mul_work;
  div_work_t mul_work_next;
  logic div_valid;
  div_work_t div_work;
  logic signed [TEMP_W+1:0] quo_signed;
  logic signed [TEMP_W+1:0] sum;
  logic [TEMP_W-1:0] out_next;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  svt_segment #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_segment (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(s_axis_tvalid),
    .voltage_mv(s_axis_tdata[MV_W-1:0]),
    .out_valid(seg_valid),
    .seg(seg)
  );

  always_comb begin
    mul_work_next.ok = seg.ok;
    mul_work_next.base = seg.base;
    mul_work_next.neg = seg.neg;
    mul_work_next.rem = NUM_W'(seg.d) * NUM_W'(seg.mag);
    mul_work_next.span = seg.span;
    mul_work_next.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (advance) begin
      mul_valid <= seg_valid;
    end
    if (advance) begin
      mul_work <= mul_work_next;
    end
  end

  svt_divider u_divider (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(mul_valid),
    .in_work(mul_work),
    .out_valid(div_valid),
    .out_work(div_work)
  );

  always_comb begin
    quo_signed = div_work.neg ? -(TEMP_W + 2)'(div_work.quo) : (TEMP_W + 2)'(div_work.quo);
    sum = (TEMP_W + 2)'(div_work.base) + quo_signed;
    out_next = sum[TEMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= div_valid;
    end
    if (advance) begin
      m_axis_tdata <= out_next;
      m_axis_tuser <= div_work.ok;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/svt_segment.sv @@
`timescale 1ns / 1ps
`default_nettype none
module svt_segment #(
  parameter int TABLE_POINTS = svt_pkg::TABLE_POINTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic in_valid,
  input  wire logic [svt_pkg::MV_W-1:0] voltage_mv,
  output logic out_valid,
  output svt_pkg::seg_t seg
);
  import svt_pkg::*;

  localparam int IDX_W = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;

  logic [TABLE_POINTS-1:0] gt_next;
  logic [TABLE_POINTS-1:0] gt;
  logic [MV_W-1:0] volt;
  logic volt_valid;

  logic found;
  logic [IDX_W-1:0] idx;
  lut_point_t lo;
  lut_point_t hi;
  logic signed [TEMP_W:0] dt;
  logic [TEMP_W:0] dt_abs;
  seg_t seg_next;

  always_comb begin
    for (int i = 0; i < TABLE_POINTS; i++) begin
      gt_next[i] = voltage_mv > lut_at(LUT_IDX_W'(i)).mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_valid <= 1'b0;
    end else if (advance) begin
      volt_valid <= in_valid;
    end
    if (advance) begin
      gt <= gt_next;
      volt <= voltage_mv;
    end
  end

  always_comb begin
    found = 1'b0;
    idx = '0;
    for (int i = TABLE_POINTS - 1; i >= 0; i--) begin
      if (gt[i]) begin
        found = 1'b1;
        idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    lo = lut_at(LUT_IDX_W'(idx));
    hi = lut_at(LUT_IDX_W'(IDX_W'(idx - 1'b1)));
    dt = {hi.temp[TEMP_W-1], hi.temp} - {lo.temp[TEMP_W-1], lo.temp};
    dt_abs = dt[TEMP_W] ? (TEMP_W + 1)'(-dt) : dt;
    seg_next.ok = found;
    seg_next.neg = 1'b0;
    seg_next.mag = '0;
    seg_next.d = '0;
    seg_next.span = MV_W'(1);
    if (!found) begin
      seg_next.base = '0;
    end else if (idx == '0) begin
      seg_next.base = lut_at('0).temp;
    end else begin
      seg_next.base = lo.temp;
      seg_next.neg = dt[TEMP_W];
      seg_next.mag = dt_abs[QUO_W-1:0];
      seg_next.d = volt - lo.mv;
      seg_next.span = hi.mv - lo.mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= volt_valid;
    end
    if (advance) begin
      seg <= seg_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/svt_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
module svt_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic in_valid,
  input  wire svt_pkg::div_work_t in_work,
  output logic out_valid,
  output svt_pkg::div_work_t out_work
);
  import svt_pkg::*;

  function automatic div_work_t div_steps(input div_work_t w, input int first_bit);
    div_work_t r;
    logic [NUM_W-1:0] trial;
    r = w;
    for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
      trial = NUM_W'(r.span) << (first_bit - j);
      if (r.rem >= trial) begin
        r.rem = r.rem - trial;
        r.quo = r.quo | (QUO_W'(1) << (first_bit - j));
      end
    end
    return r;
  endfunction

  div_work_t stage_work [DIV_STAGES];
  logic stage_valid [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_work_t work_next;
    logic valid_in;

    if (s == 0) begin : g_first
      always_comb begin
        work_next = div_steps(in_work, QUO_W - 1);
        valid_in = in_valid;
      end
    end else begin : g_rest
      always_comb begin
        work_next = div_steps(stage_work[s-1], QUO_W - 1 - s * DIV_BITS_PER_STAGE);
        valid_in = stage_valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[s] <= 1'b0;
      end else if (advance) begin
        stage_valid[s] <= valid_in;
      end
      if (advance) begin
        stage_work[s] <= work_next;
      end
    end
  end

  assign out_valid = stage_valid[DIV_STAGES-1];
  assign out_work = stage_work[DIV_STAGES-1];

endmodule
`default_nettype wire
